/* rtl/core/mbe_pkg.sv */
package mbe_pkg;

	localparam int COORD_W = 12;
	localparam int Z_W = 64;
	localparam int STEP_W = 63;
	localparam int SIZE_W = 13;
	localparam int LEVEL_W = 8;
	localparam int INDEX_W = 3;
	localparam int OFF_W = 13;
	localparam int PROD_W = 128;
	localparam int SAT_W = 78;
	localparam int ESC_BIT = 120;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [INDEX_W-1:0] REG_CENTER_X = 3'd0;
	localparam logic [INDEX_W-1:0] REG_CENTER_Y = 3'd1;
	localparam logic [INDEX_W-1:0] REG_PIXEL_STEP = 3'd2;
	localparam logic [INDEX_W-1:0] REG_VIEW_WIDTH = 3'd3;
	localparam logic [INDEX_W-1:0] REG_VIEW_HEIGHT = 3'd4;

	localparam logic [Z_W-1:0] CENTER_RESET = 64'd0;
	localparam logic [STEP_W-1:0] STEP_RESET = 63'd5764607523034235;
	localparam logic [SIZE_W-1:0] WIDTH_RESET = 13'd640;
	localparam logic [SIZE_W-1:0] HEIGHT_RESET = 13'd480;
	localparam logic [LEVEL_W-1:0] LEVEL_TOP = 8'd255;

	typedef struct packed {
		logic [Z_W-1:0] center_x;
		logic [Z_W-1:0] center_y;
		logic [STEP_W-1:0] pixel_step;
		logic [SIZE_W-1:0] view_width;
		logic [SIZE_W-1:0] view_height;
	} cfg_t;

	typedef struct packed {
		logic [Z_W-1:0] cx;
		logic [Z_W-1:0] cy;
	} point_t;

	// Clamps a signed value to the signed 64-bit range.
	function automatic logic [Z_W-1:0] sat_q(input logic [SAT_W-1:0] v);
		if (v[SAT_W-1:Z_W-1] == {(SAT_W-Z_W+1){v[Z_W-1]}}) begin
			return v[Z_W-1:0];
		end
		return v[SAT_W-1] ? {1'b1, {(Z_W-1){1'b0}}} : {1'b0, {(Z_W-1){1'b1}}};
	endfunction

endpackage

/* rtl/core/mbe_front.sv */
module mbe_front #(
	parameter int MAX_SIZE = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  mbe_pkg::cfg_t                   cfg,
	input  logic                            push,
	output logic                            full,
	input  logic [mbe_pkg::COORD_W-1:0]     column,
	input  logic [mbe_pkg::COORD_W-1:0]     row,
	output logic                            q_push,
	input  logic                            q_full,
	output mbe_pkg::point_t                 q_point
);

	logic advance;
	logic v_s1, v_s2, v_s3, v_s4;
	logic [mbe_pkg::COORD_W-1:0] half_x, half_y;
	logic signed [mbe_pkg::OFF_W-1:0] off_x_s1, off_y_s1;
	logic signed [45:0] plo_x_s2, plo_y_s2;
	logic signed [44:0] phi_x_s2, phi_y_s2;
	logic [76:0] prod_x_s3, prod_y_s3;
	logic [mbe_pkg::SAT_W-1:0] sum_x, sum_y;
	mbe_pkg::point_t point_s4;

	assign advance = !(v_s4 && q_full);
	assign full = !advance;
	assign q_push = v_s4 && !q_full;
	assign q_point = point_s4;

	always_comb begin
		if (32'(cfg.view_width) > 32'(MAX_SIZE)) begin
			half_x = 12'(MAX_SIZE / 2);
		end else begin
			half_x = cfg.view_width[mbe_pkg::SIZE_W-1:1];
		end
		if (32'(cfg.view_height) > 32'(MAX_SIZE)) begin
			half_y = 12'(MAX_SIZE / 2);
		end else begin
			half_y = cfg.view_height[mbe_pkg::SIZE_W-1:1];
		end
	end

	assign sum_x = {{14{cfg.center_x[63]}}, cfg.center_x} + {prod_x_s3[76], prod_x_s3};
	assign sum_y = {{14{cfg.center_y[63]}}, cfg.center_y} + {prod_y_s3[76], prod_y_s3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (advance) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			off_x_s1 <= $signed({1'b0, column} - {1'b0, half_x});
			off_y_s1 <= $signed({1'b0, row} - {1'b0, half_y});
			plo_x_s2 <= $signed({1'b0, cfg.pixel_step[31:0]}) * off_x_s1;
			phi_x_s2 <= $signed({1'b0, cfg.pixel_step[62:32]}) * off_x_s1;
			plo_y_s2 <= $signed({1'b0, cfg.pixel_step[31:0]}) * off_y_s1;
			phi_y_s2 <= $signed({1'b0, cfg.pixel_step[62:32]}) * off_y_s1;
			prod_x_s3 <= {phi_x_s2, 32'b0} + {{31{plo_x_s2[45]}}, plo_x_s2};
			prod_y_s3 <= {phi_y_s2, 32'b0} + {{31{plo_y_s2[45]}}, plo_y_s2};
			point_s4.cx <= mbe_pkg::sat_q(sum_x);
			point_s4.cy <= mbe_pkg::sat_q(sum_y);
		end
	end

endmodule

/* rtl/core/mbe_fifo.sv */
module mbe_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  mbe_pkg::point_t  wr_data,
	output logic             wr_full,
	input  logic             rd_en,
	output mbe_pkg::point_t  rd_data,
	output logic             rd_empty
);

	localparam int PTR_W = $clog2(mbe_pkg::QUEUE_DEPTH);
	localparam int CNT_W = $clog2(mbe_pkg::QUEUE_DEPTH + 1);

	mbe_pkg::point_t mem_q [mbe_pkg::QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic do_wr, do_rd;

	assign wr_full = (count_q == CNT_W'(mbe_pkg::QUEUE_DEPTH));
	assign rd_empty = (count_q == '0);
	assign do_wr = wr_en && !wr_full;
	assign do_rd = rd_en && !rd_empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(mbe_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(mbe_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

/* rtl/core/mbe_iter.sv */
module mbe_iter #(
	parameter int MAX_ITER = 255
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           q_empty,
	output logic                           q_pop,
	input  mbe_pkg::point_t                q_point,
	output logic                           empty,
	input  logic                           pop,
	output logic [mbe_pkg::LEVEL_W-1:0]    level
);

	typedef enum logic [6:0] {
		S_IDLE = 7'b0000001,
		S_MAG  = 7'b0000010,
		S_MUL  = 7'b0000100,
		S_ACC  = 7'b0001000,
		S_TEST = 7'b0010000,
		S_UPD  = 7'b0100000,
		S_DONE = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic [mbe_pkg::Z_W-1:0] cx_q, cy_q, zx_q, zy_q, mx_q, my_q;
	logic neg_q;
	logic [mbe_pkg::LEVEL_W-1:0] k_q, level_q;
	logic [1:0] phase_q, sh_q;
	logic pp_valid_q, out_valid_q;
	logic [63:0] pp_sx_q, pp_sy_q, pp_cr_q;
	logic [mbe_pkg::PROD_W-1:0] acc_sx_q, acc_sy_q, acc_cr_q;
	logic [mbe_pkg::PROD_W-1:0] al_sx, al_sy, al_cr, sq_sum;
	logic [mbe_pkg::PROD_W-1:0] diff_q, cross_q;
	logic [31:0] xa, xb, ya, yb;
	logic [69:0] upd_x, upd_y;
	logic stop, result_load;

	assign empty = !out_valid_q;
	assign level = level_q;
	assign q_pop = (state_q == S_IDLE) && !q_empty;
	assign result_load = (state_q == S_DONE) && (!out_valid_q || pop);

	assign xa = phase_q[1] ? mx_q[63:32] : mx_q[31:0];
	assign xb = phase_q[0] ? mx_q[63:32] : mx_q[31:0];
	assign ya = phase_q[1] ? my_q[63:32] : my_q[31:0];
	assign yb = phase_q[0] ? my_q[63:32] : my_q[31:0];

	always_comb begin
		unique case (sh_q)
			2'd0: begin
				al_sx = {64'b0, pp_sx_q};
				al_sy = {64'b0, pp_sy_q};
				al_cr = {64'b0, pp_cr_q};
			end
			2'd1: begin
				al_sx = {32'b0, pp_sx_q, 32'b0};
				al_sy = {32'b0, pp_sy_q, 32'b0};
				al_cr = {32'b0, pp_cr_q, 32'b0};
			end
			default: begin
				al_sx = {pp_sx_q, 64'b0};
				al_sy = {pp_sy_q, 64'b0};
				al_cr = {pp_cr_q, 64'b0};
			end
		endcase
	end

	assign sq_sum = acc_sx_q + acc_sy_q;
	assign stop = (k_q == mbe_pkg::LEVEL_W'(MAX_ITER))
		|| (sq_sum[mbe_pkg::PROD_W-1:mbe_pkg::ESC_BIT] != '0);

	assign upd_x = {{6{cx_q[63]}}, cx_q} + {diff_q[127], diff_q[127:59]};
	assign upd_y = {{6{cy_q[63]}}, cy_q} + cross_q[127:58];

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (!q_empty) begin
					state_d = S_MAG;
				end
			end
			S_MAG: state_d = S_MUL;
			S_MUL: begin
				if (phase_q == 2'd3) begin
					state_d = S_ACC;
				end
			end
			S_ACC: state_d = S_TEST;
			S_TEST: state_d = stop ? S_DONE : S_UPD;
			S_UPD: state_d = S_MAG;
			S_DONE: begin
				if (result_load) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			pp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			pp_valid_q <= (state_q == S_MUL);
			if (result_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cx_q <= q_point.cx;
			cy_q <= q_point.cy;
			zx_q <= q_point.cx;
			zy_q <= q_point.cy;
			k_q <= '0;
		end
		if (state_q == S_MAG) begin
			mx_q <= zx_q[63] ? (64'd0 - zx_q) : zx_q;
			my_q <= zy_q[63] ? (64'd0 - zy_q) : zy_q;
			neg_q <= zx_q[63] ^ zy_q[63];
			phase_q <= '0;
			acc_sx_q <= '0;
			acc_sy_q <= '0;
			acc_cr_q <= '0;
		end else if (pp_valid_q) begin
			acc_sx_q <= acc_sx_q + al_sx;
			acc_sy_q <= acc_sy_q + al_sy;
			acc_cr_q <= acc_cr_q + al_cr;
		end
		if (state_q == S_MUL) begin
			pp_sx_q <= xa * xb;
			pp_sy_q <= ya * yb;
			pp_cr_q <= xa * yb;
			sh_q <= 2'({1'b0, phase_q[1]} + {1'b0, phase_q[0]});
			phase_q <= phase_q + 2'd1;
		end
		if (state_q == S_TEST) begin
			diff_q <= acc_sx_q - acc_sy_q;
			cross_q <= neg_q ? (128'd0 - acc_cr_q) : acc_cr_q;
		end
		if (state_q == S_UPD) begin
			zx_q <= mbe_pkg::sat_q({{8{upd_x[69]}}, upd_x});
			zy_q <= mbe_pkg::sat_q({{8{upd_y[69]}}, upd_y});
			k_q <= k_q + 1'b1;
		end
		if (result_load) begin
			level_q <= mbe_pkg::LEVEL_TOP - k_q;
		end
	end

endmodule

/* rtl/core/mandelbrot_escape_time_pixel.sv */
// Escape-time engine for one Mandelbrot pixel per transfer.
// The input side behaves like a queue: a pixel's column and row transfer at a
// clock edge where push is high and full is low. The result side behaves
// like a queue as well: level is valid while empty is low and transfers at an
// edge where pop is high. The user must write the configuration registers
// through cfg_write, cfg_index and cfg_data only while no pixel is in flight;
// the block itself does not enforce this. A four-stage front pipeline maps
// the pixel to its plane point c and places it in a two-entry queue. The
// iteration engine then runs each pass of the recurrence as magnitudes, four
// partial-product steps on three shared 32 by 32 multipliers, a final
// accumulate, the escape test and the update. A pixel's updates stop at the
// iteration cap of 255, and the front overlaps with the engine.
// Reset clears all queues and restores the register defaults. When the
// receiver stalls, a finished level waits in the output register, the engine
// holds its next result and the front keeps accepting until its queue fills.
module mandelbrot_escape_time_pixel #(
	parameter int MAX_SIZE = 4096,
	parameter int MAX_ITER = 255
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_write,
	input  logic [mbe_pkg::INDEX_W-1:0]       cfg_index,
	input  logic [mbe_pkg::Z_W-1:0]           cfg_data,
	input  logic                              push,
	output logic                              full,
	input  logic [mbe_pkg::COORD_W-1:0]       column,
	input  logic [mbe_pkg::COORD_W-1:0]       row,
	output logic                              empty,
	input  logic                              pop,
	output logic [mbe_pkg::LEVEL_W-1:0]       level
);

	mbe_pkg::cfg_t cfg_q;
	mbe_pkg::point_t fq_in, fq_out;
	logic fq_push, fq_full, fq_pop, fq_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.center_x <= mbe_pkg::CENTER_RESET;
			cfg_q.center_y <= mbe_pkg::CENTER_RESET;
			cfg_q.pixel_step <= mbe_pkg::STEP_RESET;
			cfg_q.view_width <= mbe_pkg::WIDTH_RESET;
			cfg_q.view_height <= mbe_pkg::HEIGHT_RESET;
		end else if (cfg_write) begin
			unique case (cfg_index)
				mbe_pkg::REG_CENTER_X: cfg_q.center_x <= cfg_data;
				mbe_pkg::REG_CENTER_Y: cfg_q.center_y <= cfg_data;
				mbe_pkg::REG_PIXEL_STEP: cfg_q.pixel_step <= cfg_data[mbe_pkg::STEP_W-1:0];
				mbe_pkg::REG_VIEW_WIDTH: cfg_q.view_width <= cfg_data[mbe_pkg::SIZE_W-1:0];
				mbe_pkg::REG_VIEW_HEIGHT: cfg_q.view_height <= cfg_data[mbe_pkg::SIZE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	mbe_front #(
		.MAX_SIZE(MAX_SIZE)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.cfg(cfg_q),
		.push(push),
		.full(full),
		.column(column),
		.row(row),
		.q_push(fq_push),
		.q_full(fq_full),
		.q_point(fq_in)
	);

	mbe_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(fq_push),
		.wr_data(fq_in),
		.wr_full(fq_full),
		.rd_en(fq_pop),
		.rd_data(fq_out),
		.rd_empty(fq_empty)
	);

	mbe_iter #(
		.MAX_ITER(MAX_ITER)
	) u_iter (
		.clk(clk),
		.arst_n(arst_n),
		.q_empty(fq_empty),
		.q_pop(fq_pop),
		.q_point(fq_out),
		.empty(empty),
		.pop(pop),
		.level(level)
	);

endmodule

/* dv/mandelbrot_escape_time_pixel_tb.sv */
module mandelbrot_escape_time_pixel_tb;

	localparam int ITER_CAP = 255;
	localparam int SIZE_CAP = 4096;
	localparam int ITEM_GOAL = 950;
	localparam int CYCLE_LIMIT = 10_000_000;
	localparam int DRAIN_CYCLES = 200;
	// First index past the end of the register list; writes there are ignored.
	localparam logic [mbe_pkg::INDEX_W-1:0] REG_SPARE = 3'd5;
	localparam logic signed [129:0] Q_MAX = 130'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [129:0] Q_MIN = -Q_MAX - 130'sd1;
	localparam logic signed [129:0] ESCAPE_SQ = 130'sd1 <<< mbe_pkg::ESC_BIT;
	localparam logic signed [mbe_pkg::Z_W-1:0] Q_ONE = 64'sd1 <<< 59;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [mbe_pkg::INDEX_W-1:0] cfg_index = '0;
	logic [mbe_pkg::Z_W-1:0] cfg_data = '0;
	logic push = 1'b0;
	logic full;
	logic [mbe_pkg::COORD_W-1:0] column = '0;
	logic [mbe_pkg::COORD_W-1:0] row = '0;
	logic empty;
	logic pop = 1'b0;
	logic [mbe_pkg::LEVEL_W-1:0] level;

	logic signed [mbe_pkg::Z_W-1:0] view_cx = mbe_pkg::CENTER_RESET;
	logic signed [mbe_pkg::Z_W-1:0] view_cy = mbe_pkg::CENTER_RESET;
	logic [mbe_pkg::STEP_W-1:0] view_step = mbe_pkg::STEP_RESET;
	logic [mbe_pkg::SIZE_W-1:0] view_w = mbe_pkg::WIDTH_RESET;
	logic [mbe_pkg::SIZE_W-1:0] view_h = mbe_pkg::HEIGHT_RESET;

	logic [mbe_pkg::LEVEL_W-1:0] levels_due[$];
	logic [mbe_pkg::LEVEL_W-1:0] level_want;
	int errors = 0;
	int sent = 0;
	int cycles = 0;
	int pop_hold = 0;
	bit steady = 1'b0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	mandelbrot_escape_time_pixel dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.push(push),
		.full(full),
		.column(column),
		.row(row),
		.empty(empty),
		.pop(pop),
		.level(level)
	);

	function automatic logic signed [mbe_pkg::Z_W-1:0] clamp_q(input logic signed [129:0] v);
		if (v > Q_MAX) return Q_MAX[mbe_pkg::Z_W-1:0];
		if (v < Q_MIN) return Q_MIN[mbe_pkg::Z_W-1:0];
		return v[mbe_pkg::Z_W-1:0];
	endfunction

	function automatic logic signed [mbe_pkg::Z_W-1:0] plane_coord(
			input logic signed [mbe_pkg::Z_W-1:0] center,
			input logic [mbe_pkg::COORD_W-1:0] coord, input logic [mbe_pkg::SIZE_W-1:0] size);
		logic [mbe_pkg::SIZE_W-1:0] span;
		logic signed [129:0] offset;
		span = (size > SIZE_CAP) ? mbe_pkg::SIZE_W'(SIZE_CAP) : size;
		offset = $signed({1'b0, coord}) - $signed({1'b0, span[mbe_pkg::SIZE_W-1:1]});
		return clamp_q(center + $signed({1'b0, view_step}) * offset);
	endfunction

	function automatic logic [mbe_pkg::LEVEL_W-1:0] escape_level(
			input logic [mbe_pkg::COORD_W-1:0] col, input logic [mbe_pkg::COORD_W-1:0] rw);
		logic signed [mbe_pkg::Z_W-1:0] cx, cy, zx, zy;
		logic signed [129:0] sx, sy, cr;
		int k;
		cx = plane_coord(view_cx, col, view_w);
		cy = plane_coord(view_cy, rw, view_h);
		zx = cx;
		zy = cy;
		sx = zx * zx;
		sy = zy * zy;
		k = 0;
		while (k < ITER_CAP && (sx + sy) < ESCAPE_SQ) begin
			cr = zx * zy;
			zx = clamp_q(cx + ((sx - sy) >>> 59));
			zy = clamp_q(cy + (cr >>> 58));
			sx = zx * zx;
			sy = zy * zy;
			k++;
		end
		return mbe_pkg::LEVEL_TOP - mbe_pkg::LEVEL_W'(k);
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 24);
		return $urandom_range(60, 300);
	endfunction

	function automatic logic [mbe_pkg::Z_W-1:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	function automatic logic [mbe_pkg::SIZE_W-1:0] pick_size();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return '0;
		if (r == 1) begin
			return mbe_pkg::SIZE_W'($urandom_range(SIZE_CAP + 1, (1 << mbe_pkg::SIZE_W) - 1));
		end
		if (r == 2) return mbe_pkg::SIZE_W'(SIZE_CAP);
		if (r < 10) return mbe_pkg::SIZE_W'($urandom_range(1, 64));
		return mbe_pkg::SIZE_W'($urandom_range(1, SIZE_CAP));
	endfunction

	function automatic logic [mbe_pkg::COORD_W-1:0] pick_coord(
			input logic [mbe_pkg::SIZE_W-1:0] size);
		if (size == 0 || $urandom_range(0, 9) == 0) return mbe_pkg::COORD_W'($urandom);
		if (size > SIZE_CAP) return mbe_pkg::COORD_W'($urandom_range(0, SIZE_CAP - 1));
		return mbe_pkg::COORD_W'($urandom_range(0, size - 1));
	endfunction

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("FAILED: results differ");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			pop <= 1'b0;
		end else begin
			if (pop && !empty) begin
				if (levels_due.size() == 0) begin
					errors++;
					$display("%0t: level transfer with none expected, expected none, actual %0d",
						$time, level);
				end else begin
					level_want = levels_due.pop_front();
					if (level !== level_want) begin
						errors++;
						$display("%0t: level mismatch, expected %0d, actual %0d",
							$time, level_want, level);
					end
				end
				pop_hold = pick_gap();
			end
			if (pop_hold > 0) begin
				pop_hold--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	task automatic write_reg(input logic [mbe_pkg::INDEX_W-1:0] idx,
			input logic [mbe_pkg::Z_W-1:0] data);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			mbe_pkg::REG_CENTER_X: view_cx = data;
			mbe_pkg::REG_CENTER_Y: view_cy = data;
			mbe_pkg::REG_PIXEL_STEP: view_step = data[mbe_pkg::STEP_W-1:0];
			mbe_pkg::REG_VIEW_WIDTH: view_w = data[mbe_pkg::SIZE_W-1:0];
			mbe_pkg::REG_VIEW_HEIGHT: view_h = data[mbe_pkg::SIZE_W-1:0];
			default: ;
		endcase
		cfg_write <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_view(input logic [mbe_pkg::Z_W-1:0] cx, cy, step, w, h);
		write_reg(mbe_pkg::REG_CENTER_X, cx);
		write_reg(mbe_pkg::REG_CENTER_Y, cy);
		write_reg(mbe_pkg::REG_PIXEL_STEP, step);
		write_reg(mbe_pkg::REG_VIEW_WIDTH, w);
		write_reg(mbe_pkg::REG_VIEW_HEIGHT, h);
	endtask

	task automatic send_pixel(input logic [mbe_pkg::COORD_W-1:0] c,
			input logic [mbe_pkg::COORD_W-1:0] r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		column <= c;
		row <= r;
		@(posedge clk);
		while (full) @(posedge clk);
		levels_due.push_back(escape_level(c, r));
		sent++;
	endtask

	// The sender holds off until every pending level has transferred.
	task automatic wait_drain();
		push <= 1'b0;
		while (levels_due.size() != 0) @(posedge clk);
		@(posedge clk);
	endtask

	task automatic test_defaults();
		steady = 1'b0;
		send_pixel(12'd320, 12'd240);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'hFFF, 12'hFFF);
		send_pixel(12'hAAA, 12'h555);
		send_pixel(12'h555, 12'hAAA);
		send_pixel(12'd319, 12'd241);
	endtask

	task automatic test_extreme_registers();
		wait_drain();
		set_view(64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000, '1, '1,
			64'hFFFF_FFFF_FFFF_E000);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'hFFF, 12'hFFF);
		send_pixel(12'd2048, 12'd0);
		send_pixel(12'd0, 12'hFFF);
		wait_drain();
		set_view(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0001,
			64'd4096, 64'd4097);
		send_pixel(12'd2048, 12'd2048);
		send_pixel(12'd0, 12'd0);
	endtask

	task automatic test_zero_step();
		wait_drain();
		steady = 1'b1;
		set_view(64'd0, 64'd0, 64'h8000_0000_0000_0000, 64'd640, 64'd480);
		send_pixel(12'd0, 12'd0);
		send_pixel(12'hFFF, 12'hFFF);
		// A point with magnitude exactly two escapes before the first iteration.
		wait_drain();
		write_reg(mbe_pkg::REG_CENTER_X, Q_ONE <<< 1);
		send_pixel(12'd100, 12'd100);
		wait_drain();
		write_reg(mbe_pkg::REG_CENTER_X, -(Q_ONE <<< 1));
		send_pixel(12'd7, 12'd9);
	endtask

	task automatic test_unused_index();
		wait_drain();
		steady = 1'b0;
		set_view(Q_ONE >>> 1, 64'd0, 64'd1 << 50, 64'd1, 64'd1);
		for (int i = 0; i < 3; i++) begin
			write_reg(mbe_pkg::INDEX_W'(REG_SPARE + i), rand_word());
		end
		send_pixel(12'd0, 12'd0);
		send_pixel(12'd1, 12'd1);
	endtask

	task automatic test_random_views();
		int kind;
		int count;
		logic [mbe_pkg::Z_W-1:0] cx, cy, step, w, h;
		logic [mbe_pkg::SIZE_W-1:0] span;
		while (sent < ITEM_GOAL) begin
			wait_drain();
			steady = ($urandom_range(0, 4) == 0);
			kind = $urandom_range(0, 19);
			w = rand_word();
			w[mbe_pkg::SIZE_W-1:0] = pick_size();
			h = rand_word();
			h[mbe_pkg::SIZE_W-1:0] = pick_size();
			span = (w[mbe_pkg::SIZE_W-1:0] == 0 || w[mbe_pkg::SIZE_W-1:0] > SIZE_CAP)
				? mbe_pkg::SIZE_W'(SIZE_CAP) : w[mbe_pkg::SIZE_W-1:0];
			step = rand_word();
			if (kind < 7) begin
				cx = -(Q_ONE >>> 1) - (Q_ONE >>> 2) + (64'($urandom) << 26);
				cy = (64'($urandom) << 26) - (Q_ONE >>> 2);
				step[mbe_pkg::STEP_W-1:0] = mbe_pkg::STEP_W'((64'd3 << 59) / span);
			end else if (kind < 10) begin
				cx = -(Q_ONE >>> 1) - (Q_ONE >>> 2) + 64'($urandom);
				cy = 64'd57646075230342349 + 64'($urandom);
				step[mbe_pkg::STEP_W-1:0] = mbe_pkg::STEP_W'(1) << $urandom_range(16, 50);
			end else if (kind < 17) begin
				cx = rand_word();
				cy = rand_word();
			end else begin
				cx = $signed(rand_word()) >>> $urandom_range(3, 8);
				cy = $signed(rand_word()) >>> $urandom_range(3, 8);
				step[mbe_pkg::STEP_W-1:0] = step[mbe_pkg::STEP_W-1:0]
					>> $urandom_range(0, mbe_pkg::STEP_W - 1);
				if ($urandom_range(0, 7) == 0) step[mbe_pkg::STEP_W-1:0] = '0;
			end
			if ($urandom_range(0, 3) == 0) begin
				write_reg(mbe_pkg::INDEX_W'(REG_SPARE + $urandom_range(0, 2)), rand_word());
			end
			set_view(cx, cy, step, w, h);
			count = (kind >= 7 && kind < 10) ? $urandom_range(8, 20) : $urandom_range(15, 60);
			repeat (count) send_pixel(pick_coord(view_w), pick_coord(view_h));
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_defaults();
		test_extreme_registers();
		test_zero_step();
		test_unused_index();
		test_random_views();
		wait_drain();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

/* filelist.f */
rtl/core/mbe_pkg.sv
rtl/core/mbe_front.sv
rtl/core/mbe_fifo.sv
rtl/core/mbe_iter.sv
rtl/core/mandelbrot_escape_time_pixel.sv
dv/mandelbrot_escape_time_pixel_tb.sv
